### rtl/core/smva_pkg.sv
package smva_pkg;

  // field widths of the two channels
  localparam int SAMPLE_W    = 16;
  localparam int COUNT_W     = 16;
  localparam int FRAC_W      = 8;
  localparam int TOTAL_W     = 32;
  localparam int SUMSQ_OUT_W = 46;
  localparam int MEAN_W      = 24;
  localparam int VAR_W       = 39;
  localparam int STD_W       = 24;
  localparam int STATUS_W    = 2;

  // internal accumulator widths
  localparam int SUM_W   = 33;
  localparam int SUMSQ_W = 47;

  // packed stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = COUNT_W + TOTAL_W + SUMSQ_OUT_W + MEAN_W + VAR_W + STD_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // shared multiplier and compare/subtract unit
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int UNIT_W = 34;
  localparam int REM_W  = 32;
  localparam int QUO_W  = 40;
  localparam int NUM_W  = 48;

  // iteration counts
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = STD_W;
  localparam int CNT_W      = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [QUO_W-1:0]   MEAN_POS_MAX  = QUO_W'(24'h7F_FFFF);
  localparam logic [QUO_W-1:0]   MEAN_NEG_MAG  = QUO_W'(24'h80_0000);
  localparam logic [MEAN_W-1:0]  MEAN_POS_SAT  = 24'h7F_FFFF;
  localparam logic [MEAN_W-1:0]  MEAN_NEG_SAT  = 24'h80_0000;
  localparam logic [VAR_W-1:0]   VAR_SAT       = '1;

  // command carried in tuser of the input channel
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_SINGLE  = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_DROPPED = 2'd3
  } smva_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_SQ,
    ST_LO,
    ST_HI,
    ST_MM,
    ST_MCHK,
    ST_MDIV,
    ST_VLOAD,
    ST_VCHK,
    ST_VDIV,
    ST_SLOAD,
    ST_SQRT,
    ST_DONE
  } smva_state_t;

endpackage

### rtl/core/sample_mean_variance_accumulator_unit.sv
// channel   dir  tdata                                     tuser
// in_       in   [15:0] sample (signed)                    [0] cmd: add / report
// out_      out  [15:0] count, [47:16] total,              [1:0] status
//                [93:48] sum_squares, [117:94] mean,
//                [156:118] sample_variance, [180:157] std_dev, [183:181] zero
//
// an add transfer registers the square out of the shared
// multiplier and adds it to the sum of squares in the following cycle
// a report transfer holds in_tready low for four multiplier
// passes, two 40-step restoring divisions and a 24-step square root, all on
// one shared compare/subtract unit; the result register frees the input side
// reset is synchronous and active low; it clears the set and drops any result
// a held result only stalls the final load of the next report
module sample_mean_variance_accumulator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [smva_pkg::IN_TDATA_W-1:0]    in_tdata,   // [15:0] sample
  input  logic                               in_tuser,   // [0] cmd
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [smva_pkg::OUT_TDATA_W-1:0]   out_tdata,  // count, total, sum_squares,
                                                         // mean, sample_variance, std_dev
  output logic [smva_pkg::STATUS_W-1:0]      out_tuser   // [1:0] status
);

  import smva_pkg::*;

  smva_state_t state_r, state_nxt;

  // running set
  logic [COUNT_W-1:0]     count_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SUMSQ_W-1:0]     sumsq_r;
  logic                   dropped_r;

  // shared arithmetic
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] d_r;       // n*sumsq - sum^2
  logic [MUL_W-1:0]  m_r;       // n*(n-1)
  logic [UNIT_W-1:0] u_a, u_b, u_diff;
  logic              u_ge;

  // divider / root registers
  logic [REM_W-1:0]  div_r;
  logic [REM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  num_r;
  logic [QUO_W-1:0]  quo_r;
  logic              ovf_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MEAN_W-1:0] mean_r;
  logic [VAR_W-1:0]  var_r;

  // result register
  logic                   out_tvalid_r;
  logic [COUNT_W-1:0]     count_out_r;
  logic [TOTAL_W-1:0]     total_out_r;
  logic [SUMSQ_OUT_W-1:0] sumsq_out_r;
  logic [MEAN_W-1:0]      mean_out_r;
  logic [VAR_W-1:0]       var_out_r;
  logic [STD_W-1:0]       std_out_r;
  smva_status_t           status_out_r;

  logic                   in_fire;
  logic                   out_free;
  logic [SAMPLE_W-1:0]    sample_s;
  logic [SAMPLE_W-1:0]    sample_neg;
  logic [SAMPLE_W-1:0]    sample_mag;
  logic [SUM_W-1:0]       sum_neg;
  logic [MUL_W-1:0]       smag;
  logic [COUNT_W-1:0]     count_m1;
  logic [QUO_W-1:0]       quo_neg;
  logic [MEAN_W-1:0]      mean_sat;
  logic [VAR_W-1:0]       var_sat;
  smva_status_t           status_c;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  assign sample_s   = in_tdata[SAMPLE_W-1:0];
  assign sample_neg = '0 - sample_s;
  assign sample_mag = sample_s[SAMPLE_W-1] ? sample_neg : sample_s;

  // magnitude of the sum fits 32 bits for any set of 16-bit samples
  assign sum_neg  = '0 - sum_r;
  assign smag     = sum_r[SUM_W-1] ? sum_neg[MUL_W-1:0] : sum_r[MUL_W-1:0];
  assign count_m1 = count_r - COUNT_W'(1);

  // shared compare/subtract
  assign u_diff = u_a - u_b;
  assign u_ge   = (u_a >= u_b);

  // mean: truncated toward zero, clamped to the signed field
  assign quo_neg = '0 - quo_r;
  always_comb begin
    if (count_r == '0) begin
      mean_sat = '0;
    end else if (sum_r[SUM_W-1]) begin
      mean_sat = (quo_r > MEAN_NEG_MAG) ? MEAN_NEG_SAT : quo_neg[MEAN_W-1:0];
    end else begin
      mean_sat = (quo_r > MEAN_POS_MAX) ? MEAN_POS_SAT : quo_r[MEAN_W-1:0];
    end
  end

  // variance: zero below two samples, saturated on quotient overflow
  always_comb begin
    if (count_r < COUNT_W'(2)) begin
      var_sat = '0;
    end else if (ovf_r || quo_r[QUO_W-1]) begin
      var_sat = VAR_SAT;
    end else begin
      var_sat = quo_r[VAR_W-1:0];
    end
  end

  always_comb begin
    if (count_r == '0) begin
      status_c = STAT_EMPTY;
    end else if (dropped_r) begin
      status_c = STAT_DROPPED;
    end else if (count_r == COUNT_W'(1)) begin
      status_c = STAT_SINGLE;
    end else begin
      status_c = STAT_OK;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == CMD_REPORT) begin
            state_nxt = ST_SQ;
          end else if (count_r != COUNT_MAX) begin
            state_nxt = ST_ACC;
          end
        end
      end
      ST_ACC:   state_nxt = ST_IDLE;
      ST_SQ:    state_nxt = ST_LO;
      ST_LO:    state_nxt = ST_HI;
      ST_HI:    state_nxt = ST_MM;
      ST_MM:    state_nxt = ST_MCHK;
      ST_MCHK:  state_nxt = ST_MDIV;
      ST_MDIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_VLOAD;
        end
      end
      ST_VLOAD: state_nxt = ST_VCHK;
      ST_VCHK:  state_nxt = ST_VDIV;
      ST_VDIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SLOAD;
        end
      end
      ST_SLOAD: state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and operand selection
  always_comb begin
    in_tready = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    u_a       = {2'b00, rem_r};
    u_b       = {2'b00, div_r};
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        mul_a     = MUL_W'(sample_mag);
        mul_b     = MUL_W'(sample_mag);
      end
      ST_SQ: begin
        mul_a = smag;
        mul_b = smag;
      end
      ST_LO: begin
        mul_a = MUL_W'(count_r);
        mul_b = sumsq_r[MUL_W-1:0];
      end
      ST_HI: begin
        mul_a = MUL_W'(count_r);
        mul_b = MUL_W'(sumsq_r[SUMSQ_W-1:MUL_W]);
      end
      ST_MM: begin
        mul_a = MUL_W'(count_r);
        mul_b = MUL_W'(count_m1);
      end
      ST_MDIV, ST_VDIV: begin
        // next dividend bit shifted into the partial remainder
        u_a = {1'b0, rem_r, num_r[NUM_W-1]};
        u_b = {2'b00, div_r};
      end
      ST_SQRT: begin
        // two radicand bits per step against 4*root + 1
        u_a = {{(UNIT_W-REM_W+4){1'b0}}, rem_r[REM_W-7:0], num_r[NUM_W-1:NUM_W-2]};
        u_b = {{(UNIT_W-STD_W-2){1'b0}}, quo_r[STD_W-1:0], 2'b01};
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // control state and the running set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      sum_r        <= '0;
      sumsq_r      <= '0;
      dropped_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_tuser == CMD_ADD)) begin
            if (count_r == COUNT_MAX) begin
              dropped_r <= 1'b1;
            end else begin
              count_r <= count_r + COUNT_W'(1);
              sum_r   <= sum_r + {{(SUM_W-SAMPLE_W){sample_s[SAMPLE_W-1]}}, sample_s};
            end
          end
        end
        ST_ACC: begin
          sumsq_r <= sumsq_r + prod_r[SUMSQ_W-1:0];
        end
        ST_DONE: begin
          if (out_free) begin
            count_r      <= '0;
            sum_r        <= '0;
            sumsq_r      <= '0;
            dropped_r    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath of the report sequence
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_LO: d_r <= '0 - prod_r;
      ST_HI: d_r <= d_r + prod_r;
      ST_MM: begin
        d_r   <= d_r + {prod_r[MUL_W-1:0], {MUL_W{1'b0}}};
        // mean division: (|sum| << frac) / n
        rem_r <= '0;
        num_r <= {smag, {(NUM_W-MUL_W){1'b0}}};
        div_r <= REM_W'(count_r);
        quo_r <= '0;
        cnt_r <= '0;
      end
      ST_MCHK: begin
        ovf_r <= u_ge;
        m_r   <= prod_r[MUL_W-1:0];
      end
      ST_MDIV, ST_VDIV: begin
        rem_r <= u_ge ? u_diff[REM_W-1:0] : u_a[REM_W-1:0];
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        quo_r <= {quo_r[QUO_W-2:0], u_ge};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      ST_VLOAD: begin
        mean_r <= mean_sat;
        // variance division: (d << frac) / (n*(n-1))
        rem_r  <= d_r[PROD_W-1:MUL_W];
        num_r  <= {d_r[MUL_W-1:0], {(NUM_W-MUL_W){1'b0}}};
        div_r  <= m_r;
        quo_r  <= '0;
        cnt_r  <= '0;
      end
      ST_VCHK: begin
        ovf_r <= u_ge;
      end
      ST_SLOAD: begin
        var_r <= var_sat;
        rem_r <= '0;
        num_r <= {1'b0, var_sat, {FRAC_W{1'b0}}};
        quo_r <= '0;
        cnt_r <= '0;
      end
      ST_SQRT: begin
        rem_r <= u_ge ? u_diff[REM_W-1:0] : u_a[REM_W-1:0];
        num_r <= {num_r[NUM_W-3:0], 2'b00};
        quo_r <= {quo_r[QUO_W-2:0], u_ge};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          count_out_r  <= count_r;
          total_out_r  <= sum_r[TOTAL_W-1:0];
          sumsq_out_r  <= sumsq_r[SUMSQ_OUT_W-1:0];
          mean_out_r   <= mean_r;
          var_out_r    <= var_r;
          std_out_r    <= quo_r[STD_W-1:0];
          status_out_r <= status_c;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, std_out_r, var_out_r, mean_out_r,
                       sumsq_out_r, total_out_r, count_out_r};
  assign out_tuser  = status_out_r;

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import smva_pkg::*;

  // run shape
  localparam int DIRECTED_ROWS = 24;
  localparam int RANDOM_ITEMS  = 850;
  localparam int QUIET_TAIL    = 100;  // last transfers with no idling on either side
  localparam int HOLD_CYCLES   = 600;  // long result-side hold-off, fills the block
  localparam int DRAIN_CYCLES  = 150;  // drain time after the last report, plus margin

  localparam longint unsigned VAR_LIMIT = 64'(VAR_SAT);
  localparam longint unsigned STD_LIMIT = (64'd1 << STD_W) - 1;

  // one statistics report, first field in the top bits
  typedef struct packed {
    logic [COUNT_W-1:0]     count;
    logic [TOTAL_W-1:0]     total;
    logic [SUMSQ_OUT_W-1:0] sum_squares;
    logic [MEAN_W-1:0]      mean;
    logic [VAR_W-1:0]       variance;
    logic [STD_W-1:0]       std_dev;
    smva_status_t           status;
  } stats_t;

  // one row of the directed table; want is only used when typed is set
  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    stats_t              want;
  } step_row_t;

  localparam stats_t NO_STATS = '{'0, '0, '0, '0, '0, '0, STAT_OK};

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [15:0] sample
  logic                   in_tuser;   // [0] cmd
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // count, total, sum_squares, mean, variance, std_dev
  logic [STATUS_W-1:0]    out_tuser;  // [1:0] status

  // predicted state of the accumulator
  logic [COUNT_W-1:0]       set_count;
  logic signed [SUM_W-1:0]  set_sum;
  logic [SUMSQ_W-1:0]       set_sumsq;
  logic                     set_dropped;

  stats_t    pending_reports[$];     // reports accepted but not yet seen on the output
  step_row_t directed_rows[DIRECTED_ROWS];

  int unsigned transfers_in;
  int unsigned reports_seen;
  int unsigned status_seen[4];
  int unsigned mismatches;

  bit sink_stalls  = 1'b1;   // random result-side stalls enabled
  bit hold_request = 1'b0;   // asks the result side for one long hold-off

  sample_mean_variance_accumulator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // statistics predictor
  // ---------------------------------------------------------------------------

  // fold one sample into the set, or mark the set as having lost samples once
  // the count has saturated
  function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] raw);
    longint value;
    value = longint'($signed(raw));
    if (set_count == COUNT_MAX) begin
      set_dropped = 1'b1;
    end else begin
      set_count = set_count + 1'b1;
      set_sum   = set_sum + SUM_W'(value);
      set_sumsq = set_sumsq + SUMSQ_W'(value * value);
    end
  endfunction

  // work out the report for the current set and clear it
  function automatic stats_t close_set();
    stats_t            r;
    longint unsigned   n, sq, mag, q, rem, d, m, var_fx, sd, radicand, trial;
    longint            sum;
    n   = set_count;
    sum = set_sum;
    sq  = set_sumsq;
    mag = (sum < 0) ? -sum : sum;
    r.mean = '0;
    var_fx = 0;
    sd     = 0;

    // mean: magnitude divided, truncated toward zero, saturated to 24 bits
    if (n != 0) begin
      q = (mag << FRAC_W) / n;
      if (sum < 0) begin
        r.mean = (q > 64'(MEAN_NEG_MAG)) ? MEAN_NEG_SAT : MEAN_W'(-q);
      end else begin
        r.mean = (q > 64'(MEAN_POS_MAX)) ? MEAN_POS_SAT : MEAN_W'(q);
      end
    end

    // unbiased variance from n*sumsq - sum^2, then floor square root
    if (n >= 2) begin
      d   = n * sq - mag * mag;
      m   = n * (n - 1);
      q   = d / m;
      rem = d % m;
      if (q > (VAR_LIMIT >> FRAC_W)) begin
        var_fx = VAR_LIMIT;
      end else begin
        var_fx = (q << FRAC_W) + (rem << FRAC_W) / m;
      end
      if (var_fx > VAR_LIMIT) var_fx = VAR_LIMIT;
      radicand = var_fx << FRAC_W;
      for (int b = 31; b >= 0; b--) begin
        trial = sd | (64'd1 << b);
        if (trial * trial <= radicand) sd = trial;
      end
      if (sd > STD_LIMIT) sd = STD_LIMIT;
    end

    // empty set wins over dropped samples, which win over a single sample
    if (n == 0) begin
      r.status = STAT_EMPTY;
    end else if (set_dropped) begin
      r.status = STAT_DROPPED;
    end else if (n == 1) begin
      r.status = STAT_SINGLE;
    end else begin
      r.status = STAT_OK;
    end

    r.count       = set_count;
    r.total       = TOTAL_W'(sum);
    r.sum_squares = SUMSQ_OUT_W'(sq);
    r.variance    = VAR_W'(var_fx);
    r.std_dev     = STD_W'(sd);

    set_count   = '0;
    set_sum     = '0;
    set_sumsq   = '0;
    set_dropped = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // mostly full-range values, with the extremes, zero and small values mixed in
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      3, 4:    return SAMPLE_W'($urandom_range(0, 511)) - 16'd256;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // offer one transfer and wait for it to be taken; the predictor is updated
  // at the edge that takes it, so expectations queue in acceptance order
  task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] sample);
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    transfers_in++;
    if (cmd == CMD_REPORT) begin
      pending_reports.push_back(close_set());
    end else begin
      accumulate_sample(sample);
    end
  endtask

  // occasional idle burst between transfers
  task automatic sender_gap(input bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // stop offering until every report taken so far has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // tready pattern: random stall bursts, a single long hold-off on request,
  // otherwise always ready
  initial begin : result_sink
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // every result transfer is matched against the oldest outstanding report
  always @(posedge clk) begin : result_check
    stats_t               want;
    stats_t               got;
    logic [OUT_PAD_W-1:0] pad_bits;
    if (rst_n && out_tvalid && out_tready) begin
      {pad_bits, got.std_dev, got.variance, got.mean, got.sum_squares, got.total,
       got.count} = out_tdata;
      got.status = smva_status_t'(out_tuser);
      reports_seen++;
      status_seen[got.status]++;
      if (pending_reports.size() == 0) begin
        $error("result transfer with no report outstanding");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("count", want.count, got.count);
        check_field("total", want.total, got.total);
        check_field("sum_squares", want.sum_squares, got.sum_squares);
        check_field("mean", want.mean, got.mean);
        check_field("sample_variance", want.variance, got.variance);
        check_field("std_dev", want.std_dev, got.std_dev);
        check_field("status", want.status, got.status);
        check_field("tdata padding", '0, pad_bits);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int  random_end;
    int  set_len;
    bit  calm;
    bit  gappy;
    bit  pressure_done;

    // directed table: empty set after reset, single extreme samples, the widest
    // pair, zero and constant sets, sign mixing, a report with junk in the
    // sample field, an empty set straight after a report, toggling bit patterns
    directed_rows = '{
      '{CMD_REPORT, 16'h0000, 1'b1,
        '{16'd0, 32'd0, 46'd0, 24'd0, 39'd0, 24'd0, STAT_EMPTY}},
      '{CMD_ADD,    16'h8000, 1'b0, NO_STATS},
      '{CMD_REPORT, 16'h0000, 1'b1,
        '{16'd1, 32'hFFFF_8000, 46'd1073741824, 24'h80_0000, 39'd0, 24'd0, STAT_SINGLE}},
      '{CMD_ADD,    16'h7FFF, 1'b0, NO_STATS},
      '{CMD_REPORT, 16'h0000, 1'b1,
        '{16'd1, 32'd32767, 46'd1073676289, 24'h7F_FF00, 39'd0, 24'd0, STAT_SINGLE}},
      '{CMD_ADD,    16'h7FFF, 1'b0, NO_STATS},
      '{CMD_ADD,    16'h8000, 1'b0, NO_STATS},
      '{CMD_REPORT, 16'h0000, 1'b0, NO_STATS},
      '{CMD_ADD,    16'h0000, 1'b0, NO_STATS},
      '{CMD_ADD,    16'h0000, 1'b0, NO_STATS},
      '{CMD_REPORT, 16'h0000, 1'b1,
        '{16'd2, 32'd0, 46'd0, 24'd0, 39'd0, 24'd0, STAT_OK}},
      '{CMD_ADD,    16'h0005, 1'b0, NO_STATS},
      '{CMD_ADD,    16'h0005, 1'b0, NO_STATS},
      '{CMD_ADD,    16'h0005, 1'b0, NO_STATS},
      '{CMD_REPORT, 16'h0000, 1'b1,
        '{16'd3, 32'd15, 46'd75, 24'd1280, 39'd0, 24'd0, STAT_OK}},
      '{CMD_ADD,    16'h0001, 1'b0, NO_STATS},
      '{CMD_ADD,    16'hFFFF, 1'b0, NO_STATS},
      '{CMD_ADD,    16'h0002, 1'b0, NO_STATS},
      '{CMD_ADD,    16'hFFFE, 1'b0, NO_STATS},
      '{CMD_REPORT, 16'hFFFF, 1'b0, NO_STATS},
      '{CMD_REPORT, 16'h5555, 1'b1,
        '{16'd0, 32'd0, 46'd0, 24'd0, 39'd0, 24'd0, STAT_EMPTY}},
      '{CMD_ADD,    16'h5555, 1'b0, NO_STATS},
      '{CMD_ADD,    16'hAAAA, 1'b0, NO_STATS},
      '{CMD_REPORT, 16'h0000, 1'b0, NO_STATS}
    };

    pressure_done = 1'b0;
    set_count     = '0;
    set_sum       = '0;
    set_sumsq     = '0;
    set_dropped   = 1'b0;

    // all inputs known from time zero, reset held low first, then released
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_ADD;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part; typed rows replace the predicted report just queued
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].sample);
      if (directed_rows[i].typed) begin
        pending_reports[pending_reports.size() - 1] = directed_rows[i].want;
      end
      sender_gap(1'b1);
    end

    // random sets of random length, each closed by a report; zero- and
    // one-sample sets give the empty and single-sample cases
    random_end = transfers_in + RANDOM_ITEMS;
    while (transfers_in < random_end) begin
      calm        = (random_end - transfers_in) < QUIET_TAIL;
      sink_stalls = !calm;

      // once, part way in: long result hold-off while transfers keep coming,
      // then let everything drain before carrying on
      if (!pressure_done && transfers_in > random_end - 550) begin
        pressure_done = 1'b1;
        hold_request  = 1'b1;
        repeat (3) begin
          repeat (4) send_item(CMD_ADD, pick_sample());
          send_item(CMD_REPORT, '0);
        end
        wait_drained();
      end

      case ($urandom_range(0, 9))
        0:       set_len = 0;
        1:       set_len = 1;
        2:       set_len = 2;
        9:       set_len = $urandom_range(20, 60);
        default: set_len = $urandom_range(3, 12);
      endcase
      gappy = ($urandom_range(0, 2) != 0) && !calm;
      repeat (set_len) begin
        send_item(CMD_ADD, pick_sample());
        sender_gap(gappy);
      end
      send_item(CMD_REPORT, SAMPLE_W'($urandom()));
      sender_gap(gappy);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d input transfers, %0d reports checked", transfers_in, reports_seen);
    $display("report status: ok %0d, single %0d, empty %0d, saturated %0d",
             status_seen[STAT_OK], status_seen[STAT_SINGLE], status_seen[STAT_EMPTY],
             status_seen[STAT_DROPPED]);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
